// ===== design/smd_pkg.sv =====
// Shared types, constants and the step table for the matrix determinant unit.
// No dependencies; imported by every module of the block except smd_store.
`default_nettype none

package smd_pkg;

    // Fixed field widths
    localparam int DET_BITS    = 50;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 56;
    localparam int SIZE_W      = 3;
    localparam int TOTAL_W     = 5;
    localparam int PC_W        = 6;
    localparam int TIDX_W      = 4;
    localparam int TEMP_COUNT  = 10;
    localparam int UOP_ADDR_W  = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;

    // First step of each size's program
    localparam logic [PC_W-1:0] PC_N1 = 6'd0;
    localparam logic [PC_W-1:0] PC_N2 = 6'd1;
    localparam logic [PC_W-1:0] PC_N3 = 6'd3;
    localparam logic [PC_W-1:0] PC_N4 = 6'd12;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RDA,
        ST_RDB,
        ST_MUL,
        ST_ACC
    } seq_state_t;

    // Second multiplier operand source
    typedef enum logic [1:0] {
        BSRC_ELEM,
        BSRC_TEMP,
        BSRC_ONE
    } bsrc_t;

    // One multiply-accumulate step
    typedef struct packed {
        logic [UOP_ADDR_W-1:0] addr_a;
        bsrc_t                 bsrc;
        logic [UOP_ADDR_W-1:0] sel_b;
        logic                  neg;
        logic                  first;
        logic                  last;
        logic                  fin;
        logic [TIDX_W-1:0]     dst;
    } uop_t;

    // Sequencer to MAC unit control
    typedef struct packed {
        logic              load_a;
        logic              mul_en;
        logic              acc_en;
        bsrc_t             bsrc;
        logic [TIDX_W-1:0] tidx;
        logic              neg;
        logic              first;
        logic              wr_temp;
        logic [TIDX_W-1:0] dst;
    } mac_ctl_t;

    function automatic uop_t mk(input logic [3:0] a, input bsrc_t bs, input logic [3:0] b,
                                input logic neg, input logic first, input logic last,
                                input logic fin, input logic [3:0] dst);
        uop_t u;
        u.addr_a = a;
        u.bsrc   = bs;
        u.sel_b  = b;
        u.neg    = neg;
        u.first  = first;
        u.last   = last;
        u.fin    = fin;
        u.dst    = dst;
        return u;
    endfunction

    // Step table. Size 3: temps 0..2 are the 2x2 minors of columns 1,2 for row
    // pairs (0,1),(0,2),(1,2). Size 4: temps 0..5 are the 2x2 minors of columns
    // 2,3 for pairs 01,02,03,12,13,23; temps 6..9 the 3x3 minors of columns
    // 1..3 with row 0..3 struck out. Final sum expands down column 0.
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // size 1
            6'd0:  u = mk(4'd0,  BSRC_ONE,  4'd0, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0);
            // size 2
            6'd1:  u = mk(4'd0,  BSRC_ELEM, 4'd3, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
            6'd2:  u = mk(4'd1,  BSRC_ELEM, 4'd2, 1'b1, 1'b0, 1'b1, 1'b1, 4'd0);
            // size 3, minors
            6'd3:  u = mk(4'd1,  BSRC_ELEM, 4'd5, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
            6'd4:  u = mk(4'd2,  BSRC_ELEM, 4'd4, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0);
            6'd5:  u = mk(4'd1,  BSRC_ELEM, 4'd8, 1'b0, 1'b1, 1'b0, 1'b0, 4'd1);
            6'd6:  u = mk(4'd2,  BSRC_ELEM, 4'd7, 1'b1, 1'b0, 1'b1, 1'b0, 4'd1);
            6'd7:  u = mk(4'd4,  BSRC_ELEM, 4'd8, 1'b0, 1'b1, 1'b0, 1'b0, 4'd2);
            6'd8:  u = mk(4'd5,  BSRC_ELEM, 4'd7, 1'b1, 1'b0, 1'b1, 1'b0, 4'd2);
            // size 3, expansion
            6'd9:  u = mk(4'd0,  BSRC_TEMP, 4'd2, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
            6'd10: u = mk(4'd3,  BSRC_TEMP, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
            6'd11: u = mk(4'd6,  BSRC_TEMP, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0);
            // size 4, 2x2 minors
            6'd12: u = mk(4'd2,  BSRC_ELEM, 4'd7,  1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
            6'd13: u = mk(4'd3,  BSRC_ELEM, 4'd6,  1'b1, 1'b0, 1'b1, 1'b0, 4'd0);
            6'd14: u = mk(4'd2,  BSRC_ELEM, 4'd11, 1'b0, 1'b1, 1'b0, 1'b0, 4'd1);
            6'd15: u = mk(4'd3,  BSRC_ELEM, 4'd10, 1'b1, 1'b0, 1'b1, 1'b0, 4'd1);
            6'd16: u = mk(4'd2,  BSRC_ELEM, 4'd15, 1'b0, 1'b1, 1'b0, 1'b0, 4'd2);
            6'd17: u = mk(4'd3,  BSRC_ELEM, 4'd14, 1'b1, 1'b0, 1'b1, 1'b0, 4'd2);
            6'd18: u = mk(4'd6,  BSRC_ELEM, 4'd11, 1'b0, 1'b1, 1'b0, 1'b0, 4'd3);
            6'd19: u = mk(4'd7,  BSRC_ELEM, 4'd10, 1'b1, 1'b0, 1'b1, 1'b0, 4'd3);
            6'd20: u = mk(4'd6,  BSRC_ELEM, 4'd15, 1'b0, 1'b1, 1'b0, 1'b0, 4'd4);
            6'd21: u = mk(4'd7,  BSRC_ELEM, 4'd14, 1'b1, 1'b0, 1'b1, 1'b0, 4'd4);
            6'd22: u = mk(4'd10, BSRC_ELEM, 4'd15, 1'b0, 1'b1, 1'b0, 1'b0, 4'd5);
            6'd23: u = mk(4'd11, BSRC_ELEM, 4'd14, 1'b1, 1'b0, 1'b1, 1'b0, 4'd5);
            // size 4, 3x3 minors
            6'd24: u = mk(4'd5,  BSRC_TEMP, 4'd5, 1'b0, 1'b1, 1'b0, 1'b0, 4'd6);
            6'd25: u = mk(4'd9,  BSRC_TEMP, 4'd4, 1'b1, 1'b0, 1'b0, 1'b0, 4'd6);
            6'd26: u = mk(4'd13, BSRC_TEMP, 4'd3, 1'b0, 1'b0, 1'b1, 1'b0, 4'd6);
            6'd27: u = mk(4'd1,  BSRC_TEMP, 4'd5, 1'b0, 1'b1, 1'b0, 1'b0, 4'd7);
            6'd28: u = mk(4'd9,  BSRC_TEMP, 4'd2, 1'b1, 1'b0, 1'b0, 1'b0, 4'd7);
            6'd29: u = mk(4'd13, BSRC_TEMP, 4'd1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd7);
            6'd30: u = mk(4'd1,  BSRC_TEMP, 4'd4, 1'b0, 1'b1, 1'b0, 1'b0, 4'd8);
            6'd31: u = mk(4'd5,  BSRC_TEMP, 4'd2, 1'b1, 1'b0, 1'b0, 1'b0, 4'd8);
            6'd32: u = mk(4'd13, BSRC_TEMP, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 4'd8);
            6'd33: u = mk(4'd1,  BSRC_TEMP, 4'd3, 1'b0, 1'b1, 1'b0, 1'b0, 4'd9);
            6'd34: u = mk(4'd5,  BSRC_TEMP, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd9);
            6'd35: u = mk(4'd9,  BSRC_TEMP, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 4'd9);
            // size 4, expansion
            6'd36: u = mk(4'd0,  BSRC_TEMP, 4'd6, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
            6'd37: u = mk(4'd4,  BSRC_TEMP, 4'd7, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
            6'd38: u = mk(4'd8,  BSRC_TEMP, 4'd8, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            6'd39: u = mk(4'd12, BSRC_TEMP, 4'd9, 1'b1, 1'b0, 1'b1, 1'b1, 4'd0);
            default: u = mk(4'd0, BSRC_ONE, 4'd0, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== design/smd_store.sv =====
// Element store: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`default_nettype none

module smd_store #(
    parameter int ELEMENT_BITS = 12,
    parameter int ADDR_W       = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire logic [ADDR_W-1:0]       wr_addr,
    input  wire logic [ELEMENT_BITS-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]       rd_addr,
    output logic      [ELEMENT_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [ELEMENT_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/smd_mac.sv =====
// Shared multiply-accumulate unit with its partial-minor register file.
// Depends on smd_pkg.
`default_nettype none

module smd_mac #(
    parameter int ELEMENT_BITS = 12
) (
    input  wire logic                        aclk,
    input  wire smd_pkg::mac_ctl_t           ctl,
    input  wire logic [ELEMENT_BITS-1:0]     rd_data,
    output logic      [smd_pkg::DET_BITS-1:0] acc_next
);

    import smd_pkg::*;

    localparam int DW = DET_BITS;

    logic signed [ELEMENT_BITS-1:0]    a_reg;
    logic        [DW-1:0]              prod_reg;
    logic        [DW-1:0]              acc_reg;
    logic        [DW-1:0]              temp_reg [TEMP_COUNT];
    logic signed [DW-1:0]              b_val;
    logic signed [ELEMENT_BITS+DW-1:0] prod_full;
    logic        [DW-1:0]              term;

    always_comb begin
        case (ctl.bsrc)
            BSRC_ELEM: b_val = {{(DW-ELEMENT_BITS){rd_data[ELEMENT_BITS-1]}}, rd_data};
            BSRC_TEMP: b_val = temp_reg[ctl.tidx];
            BSRC_ONE:  b_val = {{(DW-1){1'b0}}, 1'b1};
            default:   b_val = '0;
        endcase
    end

    // Everything is kept modulo 2^DW; the final determinant always fits.
    assign prod_full = a_reg * b_val;
    assign term      = ctl.neg ? (DW'(0) - prod_reg) : prod_reg;
    assign acc_next  = ctl.first ? term : (acc_reg + term);

    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            a_reg <= rd_data;
        end
        if (ctl.mul_en) begin
            prod_reg <= prod_full[DW-1:0];
        end
        if (ctl.acc_en) begin
            acc_reg <= acc_next;
        end
        if (ctl.wr_temp) begin
            temp_reg[ctl.dst] <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/smd_seq.sv =====
// Load counter and step sequencer driving the store and the shared MAC.
// Depends on smd_pkg.
`default_nettype none

module smd_seq #(
    parameter int MAX_SIZE = 4,
    parameter int ADDR_W   = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [smd_pkg::SIZE_W-1:0]  matrix_size,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic                        out_busy,
    output logic                             wr_en,
    output logic      [ADDR_W-1:0]           wr_addr,
    output logic      [ADDR_W-1:0]           rd_addr,
    output smd_pkg::mac_ctl_t                mac_ctl,
    output logic                             done
);

    import smd_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [ADDR_W-1:0]   load_count_reg, load_count_next;
    logic [SIZE_W-1:0]   n_eff;
    logic [TOTAL_W-1:0]  total;
    logic [TOTAL_W-1:0]  count_plus;
    logic                last_elem;
    logic                accept;
    logic                advance;
    logic [PC_W-1:0]     start_pc;
    uop_t                uop;

    always_comb begin
        if (matrix_size == '0) begin
            n_eff = SIZE_W'(1);
        end else if (matrix_size > SIZE_W'(MAX_SIZE)) begin
            n_eff = SIZE_W'(MAX_SIZE);
        end else begin
            n_eff = matrix_size;
        end
    end

    assign total      = TOTAL_W'(n_eff) * TOTAL_W'(n_eff);
    assign count_plus = TOTAL_W'(load_count_reg) + TOTAL_W'(1);
    assign last_elem  = (count_plus >= total);
    assign uop        = uop_at(pc_reg);

    always_comb begin
        case (n_eff)
            3'd1:    start_pc = PC_N1;
            3'd2:    start_pc = PC_N2;
            3'd3:    start_pc = PC_N3;
            default: start_pc = PC_N4;
        endcase
    end

    assign accept  = (state_reg == ST_LOAD) && s_tvalid;
    // Final step waits while the previous determinant is still unclaimed.
    assign advance = (state_reg == ST_ACC) && !(uop.fin && out_busy);

    // Next state
    always_comb begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        load_count_next = load_count_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (last_elem) begin
                        load_count_next = '0;
                        pc_next         = start_pc;
                        state_next      = ST_RDA;
                    end else begin
                        load_count_next = load_count_reg + ADDR_W'(1);
                    end
                end
            end
            ST_RDA: state_next = ST_RDB;
            ST_RDB: state_next = ST_MUL;
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                if (advance) begin
                    if (uop.fin) begin
                        state_next = ST_LOAD;
                    end else begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_RDA;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready        = (state_reg == ST_LOAD);
        wr_en           = accept;
        wr_addr         = load_count_reg;
        rd_addr         = uop.addr_a[ADDR_W-1:0];
        mac_ctl.load_a  = 1'b0;
        mac_ctl.mul_en  = 1'b0;
        mac_ctl.acc_en  = 1'b0;
        mac_ctl.bsrc    = uop.bsrc;
        mac_ctl.tidx    = uop.sel_b;
        mac_ctl.neg     = uop.neg;
        mac_ctl.first   = uop.first;
        mac_ctl.wr_temp = 1'b0;
        mac_ctl.dst     = uop.dst;
        done            = 1'b0;
        case (state_reg)
            ST_RDB: begin
                mac_ctl.load_a = 1'b1;
                rd_addr        = uop.sel_b[ADDR_W-1:0];
            end
            ST_MUL: mac_ctl.mul_en = 1'b1;
            ST_ACC: begin
                mac_ctl.acc_en  = advance;
                mac_ctl.wr_temp = advance && uop.last && !uop.fin;
                done            = advance && uop.fin;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            pc_reg         <= '0;
            load_count_reg <= '0;
        end else begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            load_count_reg <= load_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/small_matrix_determinant_unit.sv =====
// Top level of the small matrix determinant unit.
// Depends on smd_pkg, smd_store, smd_seq and smd_mac.
//
// Usage:
//   Elements of an n x n matrix (n = matrix_size, 1..4, reset 4; 0 acts as 1,
//   values above MAX_SIZE act as MAX_SIZE) arrive row-major on the s_ channel,
//   one request per cycle while s_tready is high. The request that completes
//   the matrix starts the computation and the exact determinant (integer
//   product of the raw fixed-point elements, n times the element fraction bits)
//   leaves on the m_ channel as one request.
//   Compute: the determinant runs as a fixed list of multiply-accumulate steps
//   on one shared 12 x 50 bit multiplier, each step two store reads, a
//   multiply and an accumulate. Steps per size: 1, 2, 9, 28. After the last
//   element s_tready stays low through the final step, and the result is in
//   m_tdata in the same cycle that s_tready rises again.
//   Stall: the result sits in an output register; the next matrix loads while
//   it waits, and only the final step of the following matrix holds until the
//   earlier result is taken.
//   Reset: load count cleared, size back to 4, output empty. Store contents are
//   undefined until written. matrix_size is written through cfg_we/cfg_wdata;
//   the user must write it only while idle, the block itself does not enforce this.
`default_nettype none

module small_matrix_determinant_unit #(
    parameter int MAX_SIZE     = 4,
    parameter int ELEMENT_BITS = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [smd_pkg::SIZE_W-1:0]      cfg_wdata,    // matrix_size
    // element requests
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [smd_pkg::S_TDATA_W-1:0]   s_tdata,      // [11:0] element_value
    // determinant requests
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [smd_pkg::M_TDATA_W-1:0]   m_tdata       // [49:0] determinant_value
);

    import smd_pkg::*;

    localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [SIZE_W-1:0]       matrix_size_reg;
    logic                    m_tvalid_reg;
    logic [DET_BITS-1:0]     det_reg;
    logic                    out_busy;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ELEMENT_BITS-1:0] rd_data;
    logic [DET_BITS-1:0]     acc_next;
    logic                    done;
    mac_ctl_t                mac_ctl;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            matrix_size_reg <= cfg_wdata;
        end
    end

    // Element store: low ELEMENT_BITS of the element are kept
    smd_store #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[ELEMENT_BITS-1:0]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smd_seq #(
        .MAX_SIZE (MAX_SIZE),
        .ADDR_W   (ADDR_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .matrix_size (matrix_size_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .out_busy    (out_busy),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .mac_ctl     (mac_ctl),
        .done        (done)
    );

    smd_mac #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_mac (
        .aclk     (aclk),
        .ctl      (mac_ctl),
        .rd_data  (rd_data),
        .acc_next (acc_next)
    );

    // Output register: a finished result waits here for the receiver
    assign out_busy = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            det_reg <= acc_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DET_BITS){1'b0}}, det_reg};

endmodule

`default_nettype wire

// ===== design/smd_checker.sv =====
// Port-level checks for the small matrix determinant unit, bound to the top.
// Depends on smd_pkg and small_matrix_determinant_unit.
`default_nettype none

module smd_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [smd_pkg::M_TDATA_W-1:0] m_tdata
);

    import smd_pkg::*;

    // Output empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request pending after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Padding above the determinant stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:DET_BITS] == '0))
        else $error("result padding not zero");

    // Input closes only after a request was taken
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(s_tready) |-> $past(s_tvalid))
        else $error("s_tready dropped without an accepted element");

    // A new result appears only out of a computation, never while loading
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while loading");

endmodule

bind small_matrix_determinant_unit smd_checker u_smd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/small_matrix_determinant_unit_tb.sv =====
// Self-checking bench for small_matrix_determinant_unit: streams matrices at several sizes,
// predicts each determinant by cofactor expansion and checks every result request in order.
// Depends on smd_pkg and the design files of the block.
`default_nettype none

module small_matrix_determinant_unit_tb;

    import smd_pkg::*;

    localparam int MAX_SIZE       = 4;
    localparam int ELEM_W         = 12;
    localparam int STORE_ENTRIES  = 16;
    localparam int RANDOM_ITEMS   = 500;
    // Worst compute is a 4x4; settle well past it before a register write
    localparam int SETTLE_CYCLES  = 140;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = -(2 ** (ELEM_W - 1));
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 2 ** (ELEM_W - 1) - 1;
    // Sign pattern of a 4x4 Hadamard matrix, bit set = negative entry (row-major)
    localparam logic [15:0] HADAMARD_NEG = 16'h6CA0;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [SIZE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;     // [11:0] element_value
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // [49:0] determinant_value

    // Predictor state: image of the element store, load position, size register
    logic signed [ELEM_W-1:0] element_image [STORE_ENTRIES];
    int unsigned              load_pos  = 0;
    logic [SIZE_W-1:0]        size_reg  = SIZE_RESET;

    // Determinants still owed by the block, oldest first
    logic [DET_BITS-1:0]      pending_dets [$];

    int failure_count       = 0;
    int ready_gap           = 0;
    bit idle_en             = 1'b1;   // random gaps on both channels
    bit hold_result_channel = 1'b0;   // long receiver hold-off

    small_matrix_determinant_unit #(
        .MAX_SIZE    (MAX_SIZE),
        .ELEMENT_BITS(ELEM_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Size 0 acts as 1, anything above MAX_SIZE as MAX_SIZE
    function automatic int effective_size(input logic [SIZE_W-1:0] sz);
        if (sz < 1)
            return 1;
        if (sz > MAX_SIZE)
            return MAX_SIZE;
        return int'(sz);
    endfunction

    function automatic longint el(input int i);
        return longint'(element_image[i]);
    endfunction

    // 3x3 determinant, row-major arguments, expanded down the first column
    function automatic longint det3(input longint a0, a1, a2, a3, a4, a5, a6, a7, a8);
        return a0 * (a4 * a8 - a5 * a7) - a3 * (a1 * a8 - a2 * a7)
             + a6 * (a1 * a5 - a2 * a4);
    endfunction

    // Determinant of the leading n*n entries of the store image
    function automatic longint det_of_image(input int n);
        case (n)
            1: return el(0);
            2: return el(0) * el(3) - el(1) * el(2);
            3: return det3(el(0), el(1), el(2), el(3), el(4), el(5), el(6), el(7), el(8));
            default: begin
                return el(0)  * det3(el(5), el(6), el(7), el(9), el(10), el(11),
                                     el(13), el(14), el(15))
                     - el(4)  * det3(el(1), el(2), el(3), el(9), el(10), el(11),
                                     el(13), el(14), el(15))
                     + el(8)  * det3(el(1), el(2), el(3), el(5), el(6), el(7),
                                     el(13), el(14), el(15))
                     - el(12) * det3(el(1), el(2), el(3), el(5), el(6), el(7),
                                     el(9), el(10), el(11));
            end
        endcase
    endfunction

    // One accepted element: store it, and owe a determinant if it completes the matrix.
    // The size in force now decides completion, so a mid-load size change is covered.
    task automatic predict_element(input logic signed [ELEM_W-1:0] v);
        int     n;
        longint d;
        n = effective_size(size_reg);
        element_image[load_pos % STORE_ENTRIES] = v;
        if (load_pos + 1 >= n * n) begin
            d = det_of_image(n);
            pending_dets.push_back(d[DET_BITS-1:0]);
            load_pos = 0;
        end else begin
            load_pos = (load_pos + 1) % 32;
        end
    endtask

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------

    task automatic log_failure(input string msg);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    // Mostly no gap, some short, the odd long one
    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return ELEM_W'($urandom_range(0, 6) - 3);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Send one element request. tvalid stays high across back-to-back requests and
    // is only lowered when a gap follows, so each step sees a single update.
    task automatic send_element(input logic signed [ELEM_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - ELEM_W){1'b0}}, v};
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        predict_element(v);
    endtask

    task automatic send_matrix(input int count);
        repeat (count) send_element(random_element());
    endtask

    // Drop tvalid, wait for every owed determinant, then let any compute that an
    // incomplete load might have left in flight run out
    task automatic wait_quiet();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_dets.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write, only ever done with the block idle
    task automatic set_matrix_size(input logic [SIZE_W-1:0] sz);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= sz;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        size_reg  = sz;
    endtask

    // ------------------------------------------------------------------
    // Result side: random tready, plus the long hold-off when asked
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_ready_driver
        if (!aresetn || hold_result_channel) begin
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            m_tready  <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_gap <= pick_gap();
        end
    end

    // Each accepted result request against the oldest owed determinant
    always @(posedge aclk) begin : det_checker
        logic [DET_BITS-1:0] want;
        logic [DET_BITS-1:0] got;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata[DET_BITS-1:0];
            if (pending_dets.size() == 0) begin
                log_failure($sformatf("unexpected determinant %0d", $signed(got)));
            end else begin
                want = pending_dets.pop_front();
                if (got !== want)
                    log_failure($sformatf("determinant mismatch: expected %0d, got %0d",
                                          $signed(want), $signed(got)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset size (4) with a full-scale Hadamard pattern. Also writes every store
    // entry, so later stale reads after size changes are all defined.
    task automatic test_reset_size_extremes();
        for (int i = 0; i < 16; i++)
            send_element(HADAMARD_NEG[i] ? ELEM_MIN : ELEM_MAX);
    endtask

    // Size zero behaves as size one; then a 2x2 direct case at the extremes
    task automatic test_size_zero_and_two();
        set_matrix_size(3'd0);
        send_element(ELEM_MIN);
        send_element(ELEM_MAX);
        set_matrix_size(3'd2);
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(ELEM_MIN);
        send_element(ELEM_MAX);
    endtask

    // Shrink the size part way through a 3x3 load: the next request completes
    // the smaller matrix at once, over entries partly left from earlier
    task automatic test_size_change_mid_load();
        set_matrix_size(3'd3);
        send_matrix(5);
        set_matrix_size(3'd2);
        send_element(random_element());
    endtask

    // Receiver holds off while 4x4 matrices keep coming: the output register
    // fills, the next matrix's final step waits and s_tready goes low
    task automatic test_output_backpressure();
        set_matrix_size(3'd4);
        idle_en <= 1'b0;
        fork
            begin
                hold_result_channel <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_result_channel <= 1'b0;
            end
        join_none
        send_matrix(48);
        wait_quiet();
        idle_en <= 1'b1;
    endtask

    // Phases of whole matrices with random content at a random size setting
    // (out-of-range codes included); some phases end in an incomplete load
    task automatic test_random_matrices();
        int sent;
        int n;
        int partial;
        logic [SIZE_W-1:0] sz;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sz = SIZE_W'($urandom_range(0, 7));
            set_matrix_size(sz);
            n = effective_size(sz);
            idle_en <= ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6)) begin
                send_matrix(n * n);
                sent += n * n;
            end
            if (n > 1 && $urandom_range(0, 3) == 0) begin
                partial = $urandom_range(1, n * n - 1);
                send_matrix(partial);
                sent += partial;
            end
        end
        idle_en <= 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence and verdict
    // ------------------------------------------------------------------

    initial begin : test_sequence
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size_extremes();
        test_size_zero_and_two();
        test_size_change_mid_load();
        test_output_backpressure();
        test_random_matrices();

        wait_quiet();
        if (pending_dets.size() != 0)
            log_failure($sformatf("%0d determinants never arrived", pending_dets.size()));

        if (failure_count == 0) begin
            $display("PASS small_matrix_determinant_unit");
        end else begin
            $display("FAIL small_matrix_determinant_unit");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin : run_limit
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("FAIL small_matrix_determinant_unit");
        $finish;
    end

endmodule

`default_nettype wire
